// ----- hdl/scba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and size-class tables for the size-class block allocator.
package scba_pkg;

    localparam int ADDR_W      = 16;
    localparam int LINK_AW     = 12;
    localparam int LINK_DEPTH  = 4096;
    localparam int CLASS_COUNT = 7;
    localparam int CLS_W       = 3;
    localparam int CSZ_W       = 9;

    localparam logic [11:0] MAX_SMALL = 12'd256;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Carve order: 128, 64, 48, 32 byte classes.
    localparam logic [CLS_W-1:0] CARVE_FIRST = 3'd4;
    localparam logic [CLS_W-1:0] CARVE_LAST  = 3'd1;

    typedef logic [CLS_W-1:0] t_cls;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_MEMORY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_CARVE,
        S_OPEN
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [LINK_AW-1:0] idx;
    } t_link;

    typedef struct packed {
        logic  en;
        t_cls  cls;
        t_link value;
    } t_head_wr;

    typedef struct packed {
        logic               en;
        logic [LINK_AW-1:0] addr;
        t_link              data;
    } t_link_wr;

    typedef struct packed {
        logic               en;
        logic [LINK_AW-1:0] addr;
    } t_link_rd;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        t_status           status;
    } t_result;

    function automatic t_cls size_to_class(input logic [11:0] s);
        t_cls c;
        if (s <= 12'd16) c = 3'd0;
        else if (s <= 12'd32) c = 3'd1;
        else if (s <= 12'd48) c = 3'd2;
        else if (s <= 12'd64) c = 3'd3;
        else if (s <= 12'd128) c = 3'd4;
        else if (s <= 12'd192) c = 3'd5;
        else c = 3'd6;
        return c;
    endfunction

    function automatic logic [CSZ_W-1:0] class_size(input t_cls c);
        logic [CSZ_W-1:0] sz;
        case (c)
            3'd0:    sz = 9'd16;
            3'd1:    sz = 9'd32;
            3'd2:    sz = 9'd48;
            3'd3:    sz = 9'd64;
            3'd4:    sz = 9'd128;
            3'd5:    sz = 9'd192;
            default: sz = 9'd256;
        endcase
        return sz;
    endfunction

endpackage

// ----- hdl/scba_link_mem.sv -----
`timescale 1ns / 1ps
// Free-list link store: one write and one registered read port.
module scba_link_mem (
    input  logic              i_clk,
    input  scba_pkg::t_link_wr i_wr,
    input  scba_pkg::t_link_rd i_rd,
    output scba_pkg::t_link    o_rdata
);
    import scba_pkg::*;

    t_link r_mem [LINK_DEPTH];
    t_link r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/scba_heads.sv -----
`timescale 1ns / 1ps
// Per-class free-list heads, cleared to empty at reset.
module scba_heads (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scba_pkg::t_head_wr i_wr,
    input  scba_pkg::t_cls     i_rd_cls,
    output scba_pkg::t_link    o_rd_head
);
    import scba_pkg::*;

    t_link r_head [CLASS_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CLASS_COUNT; i++) begin
                r_head[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_head[i_wr.cls] <= i_wr.value;
        end
    end

    assign o_rd_head = r_head[i_rd_cls];

endmodule

// ----- hdl/scba_ctrl.sv -----
`timescale 1ns / 1ps
// Request sequencer: list pop and push, bump pointer, carving and page opening.
module scba_ctrl #(
    parameter int PAGE_BYTES = 4096,
    parameter int PAGE_COUNT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_action,
    input  logic [11:0]                     i_size_bytes,
    input  logic [scba_pkg::ADDR_W-1:0]     i_block_address,
    input  logic                            i_out_free,
    output scba_pkg::t_result               o_result,
    output scba_pkg::t_head_wr              o_head_wr,
    output scba_pkg::t_cls                  o_head_rd_cls,
    input  scba_pkg::t_link                 i_head,
    output scba_pkg::t_link_wr              o_link_wr,
    output scba_pkg::t_link_rd              o_link_rd,
    input  scba_pkg::t_link                 i_link_rdata
);
    import scba_pkg::*;

    localparam int OFS_W = $clog2(PAGE_BYTES + 1);
    localparam int PG_W  = $clog2(PAGE_COUNT + 1);

    t_state r_state, n_state;

    logic               r_big, n_big;
    logic               r_free, n_free;
    t_cls               r_cls_req, n_cls_req;
    logic [LINK_AW-1:0] r_addr_idx, n_addr_idx;
    logic [LINK_AW-1:0] r_pop_idx, n_pop_idx;
    t_cls               r_carve_cls, n_carve_cls;
    logic [OFS_W-1:0]   r_offset, n_offset;
    logic [OFS_W-1:0]   r_room, n_room;
    logic [PG_W-1:0]    r_pages, n_pages;
    logic [ADDR_W-1:0]  r_base, n_base;

    logic               accept;
    logic [OFS_W-1:0]   sz_req;
    logic [OFS_W-1:0]   sz_carve;
    logic [ADDR_W-1:0]  bump_addr;
    logic [ADDR_W-1:0]  new_base;
    logic               room_ok;
    logic               carve_ok;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign sz_req    = OFS_W'(class_size(r_cls_req));
    assign sz_carve  = OFS_W'(class_size(r_carve_cls));
    assign bump_addr = ADDR_W'(32'(r_base) + 32'(r_offset));
    assign new_base  = (r_pages == '0) ? r_base : ADDR_W'(32'(r_base) + 32'(PAGE_BYTES));
    assign room_ok   = r_room >= sz_req;
    assign carve_ok  = r_room >= sz_carve;
    assign o_head_rd_cls = (r_state == S_CARVE) ? r_carve_cls : r_cls_req;
    assign o_in_stall    = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_big || r_free) begin
                    if (i_out_free) n_state = S_IDLE;
                end else if (i_head.valid) begin
                    n_state = S_POP;
                end else if (room_ok) begin
                    if (i_out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_CARVE;
                end
            end
            S_POP: begin
                if (i_out_free) n_state = S_IDLE;
            end
            S_CARVE: begin
                if (!carve_ok && (r_carve_cls == CARVE_LAST)) n_state = S_OPEN;
            end
            S_OPEN: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_big       = r_big;
        n_free      = r_free;
        n_cls_req   = r_cls_req;
        n_addr_idx  = r_addr_idx;
        n_pop_idx   = r_pop_idx;
        n_carve_cls = r_carve_cls;
        n_offset    = r_offset;
        n_room      = r_room;
        n_pages     = r_pages;
        n_base      = r_base;
        o_result    = '{valid: 1'b0, addr: '0, status: ST_OK};
        o_head_wr   = '0;
        o_link_wr   = '0;
        o_link_rd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_big       = i_size_bytes > MAX_SMALL;
                    n_free      = i_action == ACT_FREE;
                    n_cls_req   = size_to_class(i_size_bytes);
                    n_addr_idx  = i_block_address[ADDR_W-1:4];
                    n_carve_cls = CARVE_FIRST;
                end
            end
            S_EXEC: begin
                if (r_big) begin
                    if (i_out_free) o_result = '{valid: 1'b1, addr: '0, status: ST_TOO_LARGE};
                end else if (r_free) begin
                    if (i_out_free) begin
                        o_link_wr = '{en: 1'b1, addr: r_addr_idx, data: i_head};
                        o_head_wr = '{en: 1'b1, cls: r_cls_req,
                                      value: '{valid: 1'b1, idx: r_addr_idx}};
                        o_result  = '{valid: 1'b1, addr: '0, status: ST_OK};
                    end
                end else if (i_head.valid) begin
                    o_link_rd = '{en: 1'b1, addr: i_head.idx};
                    n_pop_idx = i_head.idx;
                end else if (room_ok) begin
                    if (i_out_free) begin
                        o_result = '{valid: 1'b1, addr: bump_addr, status: ST_OK};
                        n_offset = r_offset + sz_req;
                        n_room   = r_room - sz_req;
                    end
                end
            end
            S_POP: begin
                if (i_out_free) begin
                    o_head_wr = '{en: 1'b1, cls: r_cls_req, value: i_link_rdata};
                    o_result  = '{valid: 1'b1, addr: {r_pop_idx, 4'b0000}, status: ST_OK};
                end
            end
            S_CARVE: begin
                if (carve_ok) begin
                    o_link_wr = '{en: 1'b1, addr: bump_addr[ADDR_W-1:4], data: i_head};
                    o_head_wr = '{en: 1'b1, cls: r_carve_cls,
                                  value: '{valid: 1'b1, idx: bump_addr[ADDR_W-1:4]}};
                    n_offset  = r_offset + sz_carve;
                    n_room    = r_room - sz_carve;
                end else if (r_carve_cls != CARVE_LAST) begin
                    n_carve_cls = r_carve_cls - 3'd1;
                end
            end
            S_OPEN: begin
                if (i_out_free) begin
                    if (r_pages >= PG_W'(PAGE_COUNT)) begin
                        o_result = '{valid: 1'b1, addr: '0, status: ST_NO_MEMORY};
                    end else begin
                        n_pages  = r_pages + PG_W'(1);
                        n_base   = new_base;
                        n_offset = sz_req;
                        n_room   = OFS_W'(PAGE_BYTES) - sz_req;
                        o_result = '{valid: 1'b1, addr: new_base, status: ST_OK};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_offset <= '0;
            r_room   <= '0;
            r_pages  <= '0;
            r_base   <= '0;
        end else begin
            r_state  <= n_state;
            r_offset <= n_offset;
            r_room   <= n_room;
            r_pages  <= n_pages;
            r_base   <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        r_big       <= n_big;
        r_free      <= n_free;
        r_cls_req   <= n_cls_req;
        r_addr_idx  <= n_addr_idx;
        r_pop_idx   <= n_pop_idx;
        r_carve_cls <= n_carve_cls;
    end

    // A link write is always half of a push onto the same block index.
    a_push_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_link_wr.en |-> (o_head_wr.en && o_head_wr.value.valid
                          && (o_head_wr.value.idx == o_link_wr.addr)))
        else $error("link write without matching head push");

    // Once a page is open, bump pointer and room always span the whole page.
    a_page_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pages != '0) |-> ((OFS_W+1)'(r_offset) + (OFS_W+1)'(r_room)
                             == (OFS_W+1)'(PAGE_BYTES)))
        else $error("page offset and room out of step");

    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> i_out_free)
        else $error("result issued into a full output register");

    a_pop_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_link_rd.en |=> (r_state == S_POP))
        else $error("link read not followed by pop completion");

endmodule

// ----- hdl/size_class_block_allocator_top.sv -----
`timescale 1ns / 1ps
// Top level of the size-class block allocator: sequencer, list heads, link store, result register.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+--------------------------------------
//  in      | to block  | i_in_valid  / o_in_stall     | i_action, i_size_bytes, i_block_address
//  out     | from block| o_out_valid / i_out_stall    | o_granted_address, o_status
//
// Sequence: a free, a too-large request or a bump grant passes through accept and execute;
//   a list pop adds a pop step, fed by the registered read of the link store.
//   A page change walks the four carve classes, carving blocks from the page leftover,
//   and then opens the page.
// Reset: synchronous, active low; all lists empty, no page open. The link store needs no
//   clearing pass: an entry is only read after the push that wrote it.
// Stalls: the result register holds one result; the next request is accepted while it waits,
//   and the sequencer holds its final step until the register is free.
module size_class_block_allocator_top #(
    parameter int PAGE_BYTES = 4096,
    parameter int PAGE_COUNT = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [11:0]                 i_size_bytes,
    input  logic [scba_pkg::ADDR_W-1:0] i_block_address,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [scba_pkg::ADDR_W-1:0] o_granted_address,
    output logic [1:0]                  o_status
);
    import scba_pkg::*;

    t_result  result;
    t_head_wr head_wr;
    t_cls     head_rd_cls;
    t_link    head;
    t_link_wr link_wr;
    t_link_rd link_rd;
    t_link    link_rdata;
    logic     out_free;

    // Result register: one request's answer, parted from the sequencer.
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_granted;
    t_status           r_status;

    // Free when empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_out_stall;

    scba_ctrl #(
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_size_bytes    (i_size_bytes),
        .i_block_address (i_block_address),
        .i_out_free      (out_free),
        .o_result        (result),
        .o_head_wr       (head_wr),
        .o_head_rd_cls   (head_rd_cls),
        .i_head          (head),
        .o_link_wr       (link_wr),
        .o_link_rd       (link_rd),
        .i_link_rdata    (link_rdata)
    );

    scba_heads u_heads (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (head_wr),
        .i_rd_cls  (head_rd_cls),
        .o_rd_head (head)
    );

    scba_link_mem u_link (
        .i_clk   (i_clk),
        .i_wr    (link_wr),
        .i_rd    (link_rd),
        .o_rdata (link_rdata)
    );

    // Load a new result, or drop the old one once the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_granted <= result.addr;
            r_status  <= result.status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_granted_address = r_granted;
    assign o_status          = r_status;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the size-class block allocator: directed and random requests.
module testbench;

    import scba_pkg::*;

    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_COUNT  = 16;
    localparam int CYCLE_LIMIT = 400000;
    // A page change carves at most three blocks; let the tail run well past that.
    localparam int TAIL_CYCLES = 32;
    localparam int REPORT_MAX  = 10;
    localparam int HOLD_CYCLES = 300;

    // Block size of each class, smallest first.
    localparam int unsigned CLASS_BYTES [CLASS_COUNT] = '{16, 32, 48, 64, 128, 192, 256};

    typedef struct {
        logic [ADDR_W-1:0] addr;
        t_status           status;
    } t_grant;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        int                cls;
    } t_live_block;

    // Arena state mirror plus the queue of grants still owed by the block.
    class grant_ledger;
        t_link       heads [CLASS_COUNT];
        t_link       links [LINK_DEPTH];
        int unsigned bump_offset;
        int unsigned room_left;
        int unsigned pages_open;
        t_grant      pending [$];
        int          failures;
        int          oom_seen;
        int          results_checked;

        function new();
            foreach (heads[i]) heads[i] = '0;
            foreach (links[i]) links[i] = '0;
            bump_offset = 0;
            room_left   = 0;
            pages_open  = 0;
            failures    = 0;
            oom_seen    = 0;
            results_checked = 0;
        endfunction

        function int class_of(logic [11:0] size);
            for (int c = 0; c < CLASS_COUNT; c++)
                if (size <= CLASS_BYTES[c]) return c;
            return CLASS_COUNT - 1;
        endfunction

        function void push_block(int cls, logic [ADDR_W-1:0] addr);
            links[addr[15:4]] = heads[cls];
            heads[cls] = '{valid: 1'b1, idx: addr[15:4]};
        endfunction

        function logic [ADDR_W-1:0] bump_addr();
            int unsigned page;
            page = (pages_open != 0) ? pages_open - 1 : 0;
            return ADDR_W'(page * PAGE_BYTES + bump_offset);
        endfunction

        // Carve the page leftover greedily, largest carve class first.
        function void carve_leftover();
            for (int c = int'(CARVE_FIRST); c >= int'(CARVE_LAST); c--) begin
                while (room_left >= CLASS_BYTES[c]) begin
                    push_block(c, bump_addr());
                    bump_offset += CLASS_BYTES[c];
                    room_left   -= CLASS_BYTES[c];
                end
            end
        endfunction

        function t_grant note_request(logic act, logic [11:0] size, logic [ADDR_W-1:0] addr);
            t_grant      g;
            int          cls;
            int unsigned bytes;
            logic [LINK_AW-1:0] idx;
            g = '{addr: '0, status: ST_OK};
            if (size > MAX_SMALL) begin
                g.status = ST_TOO_LARGE;
            end else if (act == ACT_FREE) begin
                push_block(class_of(size), addr);
            end else begin
                cls   = class_of(size);
                bytes = CLASS_BYTES[cls];
                if (heads[cls].valid) begin
                    idx        = heads[cls].idx;
                    heads[cls] = links[idx];
                    g.addr     = {idx, 4'b0000};
                end else begin
                    if (bytes > room_left) begin
                        carve_leftover();
                        if (pages_open < PAGE_COUNT) begin
                            pages_open++;
                            bump_offset = 0;
                            room_left   = PAGE_BYTES;
                        end
                    end
                    if (bytes > room_left) begin
                        g.status = ST_NO_MEMORY;
                        oom_seen++;
                    end else begin
                        g.addr = bump_addr();
                        bump_offset += bytes;
                        room_left   -= bytes;
                    end
                end
            end
            pending.push_back(g);
            return g;
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= REPORT_MAX) $display("%s", msg);
        endfunction

        function void check_grant(logic [ADDR_W-1:0] addr, logic [1:0] status);
            t_grant want;
            results_checked++;
            if (pending.size() == 0) begin
                report($sformatf("result %0d: addr %h status %0d with no request outstanding",
                                 results_checked, addr, status));
                return;
            end
            want = pending.pop_front();
            if (addr !== want.addr || status !== want.status)
                report($sformatf("result %0d: expected addr %h status %0d, got addr %h status %0d",
                                 results_checked, want.addr, want.status, addr, status));
        endfunction
    endclass

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic              i_action        = ACT_ALLOC;
    logic [11:0]       i_size_bytes    = '0;
    logic [ADDR_W-1:0] i_block_address = '0;
    logic              i_out_stall     = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [ADDR_W-1:0] o_granted_address;
    logic [1:0]        o_status;

    grant_ledger ledger = new();
    t_live_block live_blocks [$];
    int          burst_left  = 0;
    int          cycle_count = 0;

    size_class_block_allocator_top #(
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_COUNT (PAGE_COUNT)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_size_bytes      (i_size_bytes),
        .i_block_address   (i_block_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_granted_address (o_granted_address),
        .o_status          (o_status)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: end the run if the handshakes never drain.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Offer one request and hold it until the block takes it. Requests go out in
    // bursts; at the start of each burst insert a random gap, or none at all.
    task automatic offer_request(logic act, logic [11:0] size, logic [ADDR_W-1:0] addr);
        int     gap;
        t_grant g;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_size_bytes    <= size;
        i_block_address <= addr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        g = ledger.note_request(act, size, addr);
        // Track granted blocks so later frees can hand real blocks back.
        if (act == ACT_ALLOC && g.status == ST_OK)
            live_blocks.push_back('{addr: g.addr, cls: ledger.class_of(size)});
    endtask

    // Free a block still held, with any size of its class and now and then
    // a stray low nibble in the address.
    task automatic free_live_block();
        int          pick;
        int unsigned lo;
        t_live_block b;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(0, live_blocks.size() - 1);
        b    = live_blocks[pick];
        live_blocks.delete(pick);
        lo   = (b.cls == 0) ? 0 : CLASS_BYTES[b.cls - 1] + 1;
        addr = b.addr;
        if ($urandom_range(0, 3) == 0) addr[3:0] = 4'($urandom);
        offer_request(ACT_FREE, 12'($urandom_range(lo, CLASS_BYTES[b.cls])), addr);
    endtask

    // One random request. The rest above alloc_pct + free_pct is oversize traffic below 95,
    // and frees of arbitrary addresses from 95 up.
    task automatic random_request(int alloc_pct, int free_pct, int big_pct);
        int          r;
        logic [11:0] size;
        r = $urandom_range(0, 99);
        if (r < alloc_pct || (r < alloc_pct + free_pct && live_blocks.size() == 0)) begin
            size = ($urandom_range(0, 99) < big_pct) ? 12'($urandom_range(129, 256))
                                                     : 12'($urandom_range(0, 256));
            offer_request(ACT_ALLOC, size, 16'($urandom));
        end else if (r < alloc_pct + free_pct) begin
            free_live_block();
        end else if (r < 95) begin
            offer_request(1'($urandom), 12'($urandom_range(257, 4095)), 16'($urandom));
        end else begin
            offer_request(ACT_FREE, 12'($urandom_range(0, 256)), 16'($urandom));
        end
    endtask

    // Receiver: take results on a stall pattern of changing density, with long
    // hold-offs now and then so the block backs up and stalls its input.
    initial begin : receiver
        int seg_left;
        int stall_pct;
        int hold_left;
        int next_hold_at;
        seg_left     = 0;
        stall_pct    = 0;
        hold_left    = 0;
        next_hold_at = 120;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                ledger.check_grant(o_granted_address, o_status);
            if (hold_left == 0 && ledger.results_checked >= next_hold_at) begin
                hold_left     = HOLD_CYCLES;
                next_hold_at += 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(10, 60);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                seg_left--;
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin : stimulus
        int fill_count;
        fill_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Open the first page and touch every class from both ends of its range.
        offer_request(ACT_ALLOC, 12'd0,   '0);
        offer_request(ACT_ALLOC, 12'd16,  '0);
        offer_request(ACT_ALLOC, 12'd17,  '0);
        offer_request(ACT_ALLOC, 12'd32,  '0);
        offer_request(ACT_ALLOC, 12'd33,  '0);
        offer_request(ACT_ALLOC, 12'd48,  '0);
        offer_request(ACT_ALLOC, 12'd49,  '0);
        offer_request(ACT_ALLOC, 12'd64,  '0);
        offer_request(ACT_ALLOC, 12'd65,  '0);
        offer_request(ACT_ALLOC, 12'd128, '0);
        offer_request(ACT_ALLOC, 12'd129, '0);
        offer_request(ACT_ALLOC, 12'd192, '0);
        offer_request(ACT_ALLOC, 12'd193, '0);
        offer_request(ACT_ALLOC, 12'd256, '0);
        // Oversize requests, allocate and free alike, leave the arena alone.
        offer_request(ACT_ALLOC, 12'd257,  '0);
        offer_request(ACT_ALLOC, 12'd4095, '0);
        offer_request(ACT_FREE,  12'd4095, 16'hFFFF);
        // Free with an unaligned address, then pop it straight back.
        offer_request(ACT_FREE,  12'd16, 16'h0003);
        offer_request(ACT_ALLOC, 12'd10, '0);
        // Double free: the same block comes back twice.
        offer_request(ACT_FREE,  12'd1, 16'h0010);
        offer_request(ACT_FREE,  12'd1, 16'h0010);
        offer_request(ACT_ALLOC, 12'd5, '0);
        offer_request(ACT_ALLOC, 12'd5, '0);
        // Bogus free at the top of the arena, then hand it out.
        offer_request(ACT_FREE,  12'd256, 16'hFFF0);
        offer_request(ACT_ALLOC, 12'd200, '0);

        // Fill: allocate-heavy with large sizes until the pages run out a few times.
        while (ledger.oom_seen < 6 && fill_count < 900) begin
            random_request(82, 8, 75);
            fill_count++;
        end
        // Mix: churn frees and allocates over the full arena.
        repeat (100) random_request(45, 40, 20);

        i_in_valid <= 1'b0;
        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (ledger.failures == 0 && ledger.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
